[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/rpc_pkg.sv]
// ----------------------------------------------------------------------------
// rpc_pkg
// Widths, constants and item types of the point rotation pipeline.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int CRD_W              = 16;  // Q12.4 coordinate
    localparam int ANGLE_W            = 16;  // binary angle step
    localparam int GUARD_BITS         = 8;
    localparam int DIFF_W             = CRD_W + 1;
    localparam int XY_W               = 28;  // offset plus guard plus CORDIC growth
    localparam int Z_W                = 33;  // residual angle, 2^32 per turn
    localparam int ANGLE_TABLE_LEN    = 24;
    localparam int ROTATION_STAGES_DEF = 16;

    localparam int GAIN_W             = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;  // 0.60725 in Q0.30
    localparam int PROD_W             = XY_W + GAIN_W + 1;
    localparam int GAIN_SHIFT         = GAIN_W + GUARD_BITS;
    localparam int RND_W              = PROD_W - GAIN_SHIFT;
    localparam int SUM_W              = RND_W + 1;

    // atan(2^-i) in 2^32-per-turn units
    localparam logic [Z_W-1:0] ARC_TABLE [ANGLE_TABLE_LEN] = '{
        33'd536870912, 33'd316933406, 33'd167458907, 33'd85004756,
        33'd42667331,  33'd21354465,  33'd10680862,  33'd5340245,
        33'd2670163,   33'd1335087,   33'd667544,    33'd333772,
        33'd166886,    33'd83443,     33'd41722,     33'd20861,
        33'd10430,     33'd5215,      33'd2608,      33'd1304,
        33'd652,       33'd326,       33'd163,       33'd81
    };

    typedef struct packed {
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } rpc_item_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] rx;
        logic signed [CRD_W-1:0] ry;
        logic                    sat;
    } rpc_result_t;

endpackage

[rtl/rpc_prep.sv]
// ----------------------------------------------------------------------------
// rpc_prep
// Head cell: forms the scaled offset and folds the angle into a half turn.
// ----------------------------------------------------------------------------
module rpc_prep (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [rpc_pkg::CRD_W-1:0]      center_x,
    input  logic signed [rpc_pkg::CRD_W-1:0]      center_y,
    input  logic signed [rpc_pkg::CRD_W-1:0]      point_x,
    input  logic signed [rpc_pkg::CRD_W-1:0]      point_y,
    input  logic        [rpc_pkg::ANGLE_W-1:0]    turn_step,
    output logic                                  out_valid,
    output rpc_pkg::rpc_item_t                    out_item
);
    import rpc_pkg::*;

    localparam logic signed [ANGLE_W-1:0] QUARTER_POS = 16'sd16384;
    localparam logic signed [ANGLE_W-1:0] QUARTER_NEG = -16'sd16384;

    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [XY_W-1:0]    x0;
    logic signed [XY_W-1:0]    y0;
    logic signed [ANGLE_W-1:0] s;
    logic signed [ANGLE_W-1:0] s_fold;
    logic                      wide;
    logic                      valid_reg;
    rpc_item_t                 item_reg;
    rpc_item_t                 item_next;

    always_comb begin
        dx = DIFF_W'(point_x) - DIFF_W'(center_x);
        dy = DIFF_W'(point_y) - DIFF_W'(center_y);
        x0 = {{(XY_W-DIFF_W-GUARD_BITS){dx[DIFF_W-1]}}, dx, GUARD_BITS'(0)};
        y0 = {{(XY_W-DIFF_W-GUARD_BITS){dy[DIFF_W-1]}}, dy, GUARD_BITS'(0)};
        // negated step: a positive step turns the point toward decreasing math angle
        s = $signed(ANGLE_W'(0) - turn_step);
        wide = (s > QUARTER_POS) || (s < QUARTER_NEG);
        // a half turn is a flip of the sign bit in a 16-bit binary angle
        s_fold = {~s[ANGLE_W-1], s[ANGLE_W-2:0]};

        item_next.cx = center_x;
        item_next.cy = center_y;
        if (wide) begin
            item_next.x = -x0;
            item_next.y = -y0;
            item_next.z = {{(Z_W-ANGLE_W-16){s_fold[ANGLE_W-1]}}, s_fold, 16'd0};
        end else begin
            item_next.x = x0;
            item_next.y = y0;
            item_next.z = {{(Z_W-ANGLE_W-16){s[ANGLE_W-1]}}, s, 16'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/rpc_cell.sv]
// ----------------------------------------------------------------------------
// rpc_cell
// One CORDIC micro-rotation cell with a fixed shift and arc constant.
// ----------------------------------------------------------------------------
module rpc_cell #(
    parameter int STAGE = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  rpc_pkg::rpc_item_t in_item,
    output logic               out_valid,
    output rpc_pkg::rpc_item_t out_item
);
    import rpc_pkg::*;

    localparam logic signed [Z_W-1:0] ARC = $signed(ARC_TABLE[STAGE]);

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   valid_reg;
    rpc_item_t              item_reg;
    rpc_item_t              item_next;

    always_comb begin
        // floor shifts of the old coordinates
        xs = in_item.x >>> STAGE;
        ys = in_item.y >>> STAGE;
        item_next.cx = in_item.cx;
        item_next.cy = in_item.cy;
        if (!in_item.z[Z_W-1]) begin
            item_next.x = in_item.x - ys;
            item_next.y = in_item.y + xs;
            item_next.z = in_item.z - ARC;
        end else begin
            item_next.x = in_item.x + ys;
            item_next.y = in_item.y - xs;
            item_next.z = in_item.z + ARC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/rpc_gain.sv]
// ----------------------------------------------------------------------------
// rpc_gain
// Tail cell: CORDIC gain correction, rounding, center add-back and clipping.
// ----------------------------------------------------------------------------
module rpc_gain (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  rpc_pkg::rpc_item_t   in_item,
    output logic                 out_valid,
    output rpc_pkg::rpc_result_t out_result
);
    import rpc_pkg::*;

    localparam logic signed [GAIN_W:0] GAIN_S = $signed({1'b0, GAIN_Q30});
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

    logic                      valid_reg;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic signed [CRD_W-1:0]   cx_reg;
    logic signed [CRD_W-1:0]   cy_reg;
    logic signed [PROD_W-1:0]  prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_next;
    logic signed [RND_W-1:0]   rnd_x;
    logic signed [RND_W-1:0]   rnd_y;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic                      clip_x;
    logic                      clip_y;

    assign prod_x_next = in_item.x * GAIN_S;
    assign prod_y_next = in_item.y * GAIN_S;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            cx_reg     <= in_item.cx;
            cy_reg     <= in_item.cy;
        end
    end

    always_comb begin
        // round half up: the bit below the cut carries into the kept part
        rnd_x = prod_x_reg[PROD_W-1:GAIN_SHIFT] + RND_W'(prod_x_reg[GAIN_SHIFT-1]);
        rnd_y = prod_y_reg[PROD_W-1:GAIN_SHIFT] + RND_W'(prod_y_reg[GAIN_SHIFT-1]);
        sum_x = SUM_W'(cx_reg) + SUM_W'(rnd_x);
        sum_y = SUM_W'(cy_reg) + SUM_W'(rnd_y);
        clip_x = (sum_x > SAT_HI) || (sum_x < SAT_LO);
        clip_y = (sum_y > SAT_HI) || (sum_y < SAT_LO);

        if (sum_x > SAT_HI) begin
            out_result.rx = 16'sh7FFF;
        end else if (sum_x < SAT_LO) begin
            out_result.rx = 16'sh8000;
        end else begin
            out_result.rx = sum_x[CRD_W-1:0];
        end
        if (sum_y > SAT_HI) begin
            out_result.ry = 16'sh7FFF;
        end else if (sum_y < SAT_LO) begin
            out_result.ry = 16'sh8000;
        end else begin
            out_result.ry = sum_y[CRD_W-1:0];
        end
        out_result.sat = clip_x || clip_y;
    end

    assign out_valid = valid_reg;

endmodule

[rtl/rotate_point_about_center.sv]
// ----------------------------------------------------------------------------
// rotate_point_about_center
// Rotates a Q12.4 point about a center by a binary angle step (CORDIC chain).
// ----------------------------------------------------------------------------
// Takes one item per clock while the skid entry is free and returns one
// result per item, in order. Each item gives a center, a point and a step
// (65536 units per turn); a positive step turns the point clockwise with y
// up. The result is the center plus the rotated offset, clipped to the
// signed 16-bit range, with m_tuser set when either coordinate was clipped.
// The path holds one head cell that folds the angle, one cell per CORDIC
// micro-rotation, one gain cell with the multiplier, and the output
// register. Throughput is set by the cell chain, which advances every cycle:
// a two-entry output register and skid buffer keep input acceptance running
// while a result waits, and the chain holds only once both entries are full.
// ----------------------------------------------------------------------------
module rotate_point_about_center #(
    parameter int ROTATION_STAGES = rpc_pkg::ROTATION_STAGES_DEF  // 8 to 24
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // center_x [15:0], center_y [31:16], point_x [47:32], point_y [63:48],
    // turn_step [79:64]
    input  logic [79:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // rotated_x [15:0], rotated_y [31:16]
    output logic [31:0] m_tdata,
    // saturated [0]
    output logic        m_tuser
);
    import rpc_pkg::*;

    `include "assert_macros.svh"

    // chain taps: tap 0 is the head cell, tap k is after micro-rotation k
    logic      stage_valid [ROTATION_STAGES+1];
    rpc_item_t stage_item  [ROTATION_STAGES+1];

    logic        en;
    logic        pipe_valid;
    rpc_result_t pipe_result;

    logic        out_valid_reg;
    logic        out_valid_next;
    rpc_result_t out_data_reg;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    rpc_result_t skid_data_reg;
    logic        load_out;
    logic        load_skid;
    logic        out_from_skid;

    // Advance the whole chain unless the skid entry is occupied.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    rpc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .center_x  ($signed(s_tdata[15:0])),
        .center_y  ($signed(s_tdata[31:16])),
        .point_x   ($signed(s_tdata[47:32])),
        .point_y   ($signed(s_tdata[63:48])),
        .turn_step (s_tdata[79:64]),
        .out_valid (stage_valid[0]),
        .out_item  (stage_item[0])
    );

    // One cell per micro-rotation, each with its own shift and arc constant.
    for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_cell
        rpc_cell #(
            .STAGE (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stage_valid[k]),
            .in_item   (stage_item[k]),
            .out_valid (stage_valid[k+1]),
            .out_item  (stage_item[k+1])
        );
    end

    rpc_gain u_gain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (stage_valid[ROTATION_STAGES]),
        .in_item    (stage_item[ROTATION_STAGES]),
        .out_valid  (pipe_valid),
        .out_result (pipe_result)
    );

    // Output register plus skid entry. The skid catches the item that the
    // chain hands over in the cycle the output stalls; draining it reopens
    // the input side.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (skid_valid_reg) begin
            // drain the skid into the output once the current item leaves
            if (m_tready) begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (out_valid_reg && !m_tready) begin
            // output stalled: park any arriving item in the skid
            if (pipe_valid) begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else begin
            load_out       = 1'b1;
            out_valid_next = pipe_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= pipe_result;
        end else if (out_from_skid) begin
            out_data_reg <= skid_data_reg;
        end
        if (load_skid) begin
            skid_data_reg <= pipe_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.ry, out_data_reg.rx};
    assign m_tuser  = out_data_reg.sat;

    // An occupied skid always sits behind a valid output item.
    `ASSERT_IMPLIES(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid holds an item while output is empty")

    // The skid fills only from a stalled output.
    `ASSERT_IMPLIES(a_skid_fill_on_stall, aclk, aresetn, $rose(skid_valid_reg), $past(m_tvalid && !m_tready), "skid filled without an output stall")

    // Draining the skid leaves a valid item at the output.
    `ASSERT_NEXT(a_skid_drain, aclk, aresetn, skid_valid_reg && m_tready, m_tvalid, "skid drain lost an item")

    // Input is refused exactly while the skid is occupied.
    `ASSERT_IMPLIES(a_ready_when_skid_free, aclk, aresetn, !s_tready, skid_valid_reg && out_valid_reg, "input refused with free skid")

endmodule
